### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the mesher modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define VFCM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// expression must never be true outside reset
`define VFCM_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define VFCM_ASSERT(lbl, clk, rst, prop, msg)
`define VFCM_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

### hdl/vfcm_pkg.sv
// ----------------------------------------------------------------------------
// vfcm_pkg
// Shared constants, command/status structs and lookup functions of the
// voxel face culling mesher.
// ----------------------------------------------------------------------------
package vfcm_pkg;

   // cube geometry
   localparam int CHUNK_EDGE     = 32;
   localparam int STORE_DEPTH    = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
   localparam int ADDR_W         = $clog2(STORE_DEPTH);
   localparam int POS_W          = 5;
   localparam int NB_W           = POS_W + 2;
   localparam int VERT_W         = 6;
   localparam int MAT_W          = 8;
   localparam int FACE_W         = 3;
   localparam int NUM_FACES      = 6;
   localparam int VERTS_PER_FACE = 6;
   localparam int STEP_W         = 3;

   // command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_MESH  = 1'b1;

   // face codes
   localparam logic [FACE_W-1:0] FACE_TOP    = 3'd0;
   localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd1;
   localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd2;
   localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd3;
   localparam logic [FACE_W-1:0] FACE_BACK   = 3'd4;
   localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd5;

   // read steps: the center voxel first, then one step per face
   localparam logic [STEP_W-1:0] STEP_CENTER = 3'd0;
   localparam logic [STEP_W-1:0] STEP_LAST   = STEP_W'(NUM_FACES);

   typedef logic [NUM_FACES-1:0] face_mask_type;

   typedef struct packed {
      logic              clr_en;
      logic              wr_en;
      logic              load;
      logic              rd_en;
      logic [STEP_W-1:0] rd_idx;
      logic              emit_load;
      logic              emit_step;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic mat_zero;
      logic mask_zero;
      logic out_free;
      logic vert_last;
   } dp_sts_type;

   // corner offset {dx, dy, dz} of one vertex of one face
   function automatic logic [2:0] corner_of(input logic [FACE_W-1:0] face,
                                            input logic [2:0] vert);
      logic [17:0] row;
      int          sel;
      case (face)
         FACE_TOP:    row = 18'b010_011_111_010_111_110;
         FACE_BOTTOM: row = 18'b000_101_001_000_100_101;
         FACE_RIGHT:  row = 18'b100_110_111_100_111_101;
         FACE_LEFT:   row = 18'b000_011_010_000_001_011;
         FACE_BACK:   row = 18'b000_010_110_000_110_100;
         FACE_FRONT:  row = 18'b001_111_011_001_101_111;
         default:     row = '0;
      endcase
      sel = (VERTS_PER_FACE - 1 - int'(vert)) * 3;
      if (sel < 0) sel = 0;
      return row[sel +: 3];
   endfunction

   // linear store address, x fastest, then z, then y
   function automatic logic [ADDR_W-1:0] addr_of(input logic [NB_W-1:0] x,
                                                 input logic [NB_W-1:0] y,
                                                 input logic [NB_W-1:0] z);
      return ADDR_W'(x) + ADDR_W'(32'(z) * CHUNK_EDGE) +
             ADDR_W'(32'(y) * (CHUNK_EDGE * CHUNK_EDGE));
   endfunction

   // coordinates inside the cube
   function automatic logic in_cube(input logic [NB_W-1:0] x,
                                    input logic [NB_W-1:0] y,
                                    input logic [NB_W-1:0] z);
      return (x < NB_W'(CHUNK_EDGE)) && (y < NB_W'(CHUNK_EDGE)) &&
             (z < NB_W'(CHUNK_EDGE));
   endfunction

   // index of the lowest set bit of a face mask
   function automatic logic [FACE_W-1:0] low_face(input face_mask_type mask);
      logic [FACE_W-1:0] idx;
      idx = '0;
      for (int i = NUM_FACES - 1; i >= 0; i--) begin
         if (mask[i]) idx = FACE_W'(i);
      end
      return idx;
   endfunction

endpackage

### hdl/voxel_face_culling_mesher.sv
// Write transaction: stored at its accept edge, one per cycle, no result.
// Mesh transaction: seven store reads on the store's read port, then check;
// then vertices, one per cycle while the output register is free.
// Reset (synchronous, active high) starts a clearing pass over all 32768 store
// entries, one entry per cycle; req_ready stays low until it ends.
// ----------------------------------------------------------------------------
// voxel_face_culling_mesher
// Voxel store with per-voxel face culling; emits six vertices per exposed
// face of a meshed voxel.
// ----------------------------------------------------------------------------
module voxel_face_culling_mesher (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_command,
   input  logic [vfcm_pkg::POS_W-1:0]    req_pos_x,
   input  logic [vfcm_pkg::POS_W-1:0]    req_pos_y,
   input  logic [vfcm_pkg::POS_W-1:0]    req_pos_z,
   input  logic [vfcm_pkg::MAT_W-1:0]    req_voxel_value,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [vfcm_pkg::VERT_W-1:0]   rsp_vert_x,
   output logic [vfcm_pkg::VERT_W-1:0]   rsp_vert_y,
   output logic [vfcm_pkg::VERT_W-1:0]   rsp_vert_z,
   output logic [vfcm_pkg::MAT_W-1:0]    rsp_material,
   output logic [vfcm_pkg::FACE_W-1:0]   rsp_face_code,
   output logic                          rsp_last
);
   import vfcm_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   // sequencer
   vfcm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .cmd         (cmd),
      .sts         (sts)
   );

   // store and vertex generation
   vfcm_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_pos_z       (req_pos_z),
      .req_voxel_value (req_voxel_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_vert_x      (rsp_vert_x),
      .rsp_vert_y      (rsp_vert_y),
      .rsp_vert_z      (rsp_vert_z),
      .rsp_material    (rsp_material),
      .rsp_face_code   (rsp_face_code),
      .rsp_last        (rsp_last)
   );

endmodule

### hdl/vfcm_ctrl.sv
// ----------------------------------------------------------------------------
// vfcm_ctrl
// Sequencer of the mesher: store clearing after reset, command acceptance,
// the seven store reads of a mesh command and vertex emission.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vfcm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_command,
   output vfcm_pkg::dp_cmd_type  cmd,
   input  vfcm_pkg::dp_sts_type  sts
);
   import vfcm_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_WAIT,
      ST_CHECK,
      ST_EMIT
   } state_type;

   state_type         state_ff;
   logic [STEP_W-1:0] step_ff;
   logic              ready_ff;
   logic              accept;

   assign accept    = req_valid && ready_ff;
   assign req_ready = ready_ff;

   // decode commands to the datapath
   always_comb begin
      cmd        = '0;
      cmd.rd_idx = step_ff;
      unique case (state_ff)
         ST_CLEAR: cmd.clr_en    = 1'b1;
         ST_IDLE: begin
            cmd.wr_en = accept && (req_command == CMD_WRITE);
            cmd.load  = accept && (req_command == CMD_MESH);
         end
         ST_READ:  cmd.rd_en     = 1'b1;
         ST_WAIT:  ;
         ST_CHECK: cmd.emit_load = !sts.mat_zero && !sts.mask_zero;
         ST_EMIT:  cmd.emit_step = sts.out_free;
         default:  ;
      endcase
   end

   // advance state, read step and ready
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         step_ff  <= '0;
         ready_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               if (sts.clr_last) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            ST_IDLE: begin
               if (cmd.load) begin
                  state_ff <= ST_READ;
                  step_ff  <= STEP_CENTER;
                  ready_ff <= 1'b0;
               end
            end
            ST_READ: begin
               if (step_ff == STEP_LAST) state_ff <= ST_WAIT;
               else step_ff <= step_ff + STEP_W'(1);
            end
            ST_WAIT: state_ff <= ST_CHECK;
            ST_CHECK: begin
               if (cmd.emit_load) begin
                  state_ff <= ST_EMIT;
               end else begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            ST_EMIT: begin
               if (cmd.emit_step && sts.vert_last) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `VFCM_ASSERT(a_ready_idle, clock, reset, req_ready |-> state_ff == ST_IDLE, "ready outside idle")
   `VFCM_ASSERT(a_emit_free, clock, reset, cmd.emit_step |-> sts.out_free, "vertex overwrites output")
   `VFCM_ASSERT(a_done_ready, clock, reset, (cmd.emit_step && sts.vert_last) |=> req_ready, "no ready after last vertex")

endmodule

### hdl/vfcm_datapath.sv
// ----------------------------------------------------------------------------
// vfcm_datapath
// Voxel store, neighbor address generation, face mask capture and the
// vertex generator with its output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vfcm_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  vfcm_pkg::dp_cmd_type                cmd,
   output vfcm_pkg::dp_sts_type                sts,
   input  logic [vfcm_pkg::POS_W-1:0]          req_pos_x,
   input  logic [vfcm_pkg::POS_W-1:0]          req_pos_y,
   input  logic [vfcm_pkg::POS_W-1:0]          req_pos_z,
   input  logic [vfcm_pkg::MAT_W-1:0]          req_voxel_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [vfcm_pkg::VERT_W-1:0]         rsp_vert_x,
   output logic [vfcm_pkg::VERT_W-1:0]         rsp_vert_y,
   output logic [vfcm_pkg::VERT_W-1:0]         rsp_vert_z,
   output logic [vfcm_pkg::MAT_W-1:0]          rsp_material,
   output logic [vfcm_pkg::FACE_W-1:0]         rsp_face_code,
   output logic                                rsp_last
);
   import vfcm_pkg::*;

   logic [MAT_W-1:0]  store_mem [STORE_DEPTH];

   logic [POS_W-1:0]  pos_x_ff, pos_y_ff, pos_z_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [STEP_W-1:0] rd_idx_ff;
   logic              rd_vld_ff;
   logic              rd_inb_ff;
   logic [MAT_W-1:0]  mem_q_ff;
   logic [MAT_W-1:0]  mat_ff;
   face_mask_type     mask_ff;
   logic [FACE_W-1:0] face_ff, face_in;
   logic [2:0]        vert_ff, vert_in;

   logic              rsp_valid_ff, rsp_last_ff;
   logic [VERT_W-1:0] rsp_vert_x_ff, rsp_vert_y_ff, rsp_vert_z_ff;
   logic [MAT_W-1:0]  rsp_material_ff;
   logic [FACE_W-1:0] rsp_face_code_ff;

   logic [NB_W-1:0]   nb_x, nb_y, nb_z;
   logic [FACE_W-1:0] rd_face, cap_face;
   logic              nb_inb;
   logic [ADDR_W-1:0] rd_addr;
   logic [NB_W-1:0]   wr_x, wr_y, wr_z;
   logic              wr_go;
   logic [ADDR_W-1:0] wr_addr;
   logic [MAT_W-1:0]  wr_data;
   face_mask_type     hi_mask;
   logic              face_end, vert_end;
   logic [2:0]        corner;

   // neighbor coordinates of the current read step; minus one at zero wraps
   // to a large value and so falls outside the cube
   assign rd_face = cmd.rd_idx - STEP_W'(1);
   always_comb begin
      nb_x = NB_W'(pos_x_ff);
      nb_y = NB_W'(pos_y_ff);
      nb_z = NB_W'(pos_z_ff);
      if (cmd.rd_idx != STEP_CENTER) begin
         case (rd_face)
            FACE_TOP:    nb_y = nb_y + NB_W'(1);
            FACE_BOTTOM: nb_y = nb_y - NB_W'(1);
            FACE_RIGHT:  nb_x = nb_x + NB_W'(1);
            FACE_LEFT:   nb_x = nb_x - NB_W'(1);
            FACE_BACK:   nb_z = nb_z - NB_W'(1);
            FACE_FRONT:  nb_z = nb_z + NB_W'(1);
            default:     ;
         endcase
      end
   end
   assign nb_inb  = in_cube(nb_x, nb_y, nb_z);
   assign rd_addr = addr_of(nb_x, nb_y, nb_z);

   // write port: clearing sweep or a write transaction
   assign wr_x    = NB_W'(req_pos_x);
   assign wr_y    = NB_W'(req_pos_y);
   assign wr_z    = NB_W'(req_pos_z);
   assign wr_go   = cmd.clr_en || (cmd.wr_en && in_cube(wr_x, wr_y, wr_z));
   assign wr_addr = cmd.clr_en ? clr_addr_ff : addr_of(wr_x, wr_y, wr_z);
   assign wr_data = cmd.clr_en ? '0 : req_voxel_value;

   // voxel store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_go) store_mem[wr_addr] <= wr_data;
      if (cmd.rd_en) mem_q_ff <= store_mem[rd_addr];
   end

   // face walk: next exposed face after the current one
   assign hi_mask  = mask_ff & (face_mask_type'('1) << (face_ff + FACE_W'(1)));
   assign face_end = (hi_mask == '0);
   assign vert_end = (vert_ff == 3'(VERTS_PER_FACE - 1));
   assign corner   = corner_of(face_ff, vert_ff);

   always_comb begin
      face_in = face_ff;
      vert_in = vert_ff;
      if (cmd.emit_load) begin
         face_in = low_face(mask_ff);
         vert_in = '0;
      end else if (cmd.emit_step) begin
         if (vert_end) begin
            face_in = low_face(hi_mask);
            vert_in = '0;
         end else begin
            vert_in = vert_ff + 3'd1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_en) clr_addr_ff <= clr_addr_ff + ADDR_W'(1);
         rd_vld_ff <= cmd.rd_en;
         if (cmd.emit_step) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // capture item, read results, face mask and output payload
   assign cap_face = rd_idx_ff - STEP_W'(1);
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pos_x_ff <= req_pos_x;
         pos_y_ff <= req_pos_y;
         pos_z_ff <= req_pos_z;
      end
      if (cmd.rd_en) begin
         rd_idx_ff <= cmd.rd_idx;
         rd_inb_ff <= nb_inb;
      end
      if (rd_vld_ff) begin
         if (rd_idx_ff == STEP_CENTER) mat_ff <= rd_inb_ff ? mem_q_ff : '0;
         else mask_ff[cap_face] <= !rd_inb_ff || (mem_q_ff == '0);
      end
      face_ff <= face_in;
      vert_ff <= vert_in;
      if (cmd.emit_step) begin
         rsp_vert_x_ff    <= VERT_W'(pos_x_ff) + VERT_W'(corner[2]);
         rsp_vert_y_ff    <= VERT_W'(pos_y_ff) + VERT_W'(corner[1]);
         rsp_vert_z_ff    <= VERT_W'(pos_z_ff) + VERT_W'(corner[0]);
         rsp_material_ff  <= mat_ff;
         rsp_face_code_ff <= face_ff;
         rsp_last_ff      <= face_end && vert_end;
      end
   end

   // status to the controller
   assign sts.clr_last  = (clr_addr_ff == ADDR_W'(STORE_DEPTH - 1));
   assign sts.mat_zero  = (mat_ff == '0);
   assign sts.mask_zero = (mask_ff == '0);
   assign sts.out_free  = !rsp_valid_ff || rsp_ready;
   assign sts.vert_last = face_end && vert_end;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_vert_x    = rsp_vert_x_ff;
   assign rsp_vert_y    = rsp_vert_y_ff;
   assign rsp_vert_z    = rsp_vert_z_ff;
   assign rsp_material  = rsp_material_ff;
   assign rsp_face_code = rsp_face_code_ff;
   assign rsp_last      = rsp_last_ff;

   `VFCM_NEVER(a_clr_wr, clock, reset, cmd.clr_en && cmd.wr_en, "write during clearing")
   `VFCM_ASSERT(a_mat_set, clock, reset, rsp_valid_ff |-> rsp_material_ff != '0, "vertex of empty voxel")
   `VFCM_ASSERT(a_face_ok, clock, reset, cmd.emit_step |-> mask_ff[face_ff], "vertex of hidden face")

endmodule
